@@ design/qoa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qoa_pkg
// Shared types, step schedule and controller encodings for the quaternion
// orientation accumulator.
// ----------------------------------------------------------------------------
package qoa_pkg;

	localparam int STEP_W = 6;
	localparam int DEST_W = 4;

	// schedule: 16 Hamilton product terms, then 18 matrix terms
	localparam logic [STEP_W-1:0] HAM_FIRST = 6'd0;
	localparam logic [STEP_W-1:0] HAM_LAST  = 6'd15;
	localparam logic [STEP_W-1:0] MAT_FIRST = 6'd16;
	localparam logic [STEP_W-1:0] MAT_LAST  = 6'd33;

	// destinations below this one are the new quaternion, the rest matrix entries
	localparam logic [DEST_W-1:0] DEST_MAT0 = 4'd4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_MUL  = 1'b1;

	typedef enum logic [1:0] {
		C_X = 2'd0,
		C_Y = 2'd1,
		C_Z = 2'd2,
		C_W = 2'd3
	} comp_t;

	typedef struct packed {
		comp_t             a_sel;
		comp_t             b_sel;
		logic              b_given;
		logic              neg;
		logic              dbl;
		logic              first;
		logic              ones;
		logic              last;
		logic [DEST_W-1:0] dest;
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_HAM    = 3'd1,
		ST_HDRAIN = 3'd2,
		ST_WAIT   = 3'd3,
		ST_MAT    = 3'd4,
		ST_MDRAIN = 3'd5
	} state_t;

	typedef struct packed {
		logic              capture;
		logic              load_orient;
		logic              issue;
		logic [STEP_W-1:0] step;
		logic              commit;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} sts_t;

	function automatic op_t mk_op(comp_t a, comp_t b, logic g, logic n, logic d,
			logic f, logic o, logic l, logic [DEST_W-1:0] dst);
		op_t r;
		r.a_sel   = a;
		r.b_sel   = b;
		r.b_given = g;
		r.neg     = n;
		r.dbl     = d;
		r.first   = f;
		r.ones    = o;
		r.last    = l;
		r.dest    = dst;
		return r;
	endfunction

	// one product per step; args: a, b, b from given, neg, x2, first, +1.0, last, dest
	function automatic op_t step_op(logic [STEP_W-1:0] s);
		op_t r;
		r = '0;
		unique case (s)
			6'd0:  r = mk_op(C_W, C_X, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0);
			6'd1:  r = mk_op(C_X, C_W, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
			6'd2:  r = mk_op(C_Y, C_Z, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
			6'd3:  r = mk_op(C_Z, C_Y, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0);
			6'd4:  r = mk_op(C_W, C_Y, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd1);
			6'd5:  r = mk_op(C_X, C_Z, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd1);
			6'd6:  r = mk_op(C_Y, C_W, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd1);
			6'd7:  r = mk_op(C_Z, C_X, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1);
			6'd8:  r = mk_op(C_W, C_Z, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd2);
			6'd9:  r = mk_op(C_X, C_Y, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd2);
			6'd10: r = mk_op(C_Y, C_X, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd2);
			6'd11: r = mk_op(C_Z, C_W, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd2);
			6'd12: r = mk_op(C_W, C_W, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd3);
			6'd13: r = mk_op(C_X, C_X, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd3);
			6'd14: r = mk_op(C_Y, C_Y, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd3);
			6'd15: r = mk_op(C_Z, C_Z, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd3);
			6'd16: r = mk_op(C_Y, C_Y, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 4'd4);
			6'd17: r = mk_op(C_Z, C_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 4'd4);
			6'd18: r = mk_op(C_X, C_Y, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd5);
			6'd19: r = mk_op(C_Z, C_W, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd5);
			6'd20: r = mk_op(C_X, C_Z, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd6);
			6'd21: r = mk_op(C_Y, C_W, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 4'd6);
			6'd22: r = mk_op(C_X, C_Y, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd7);
			6'd23: r = mk_op(C_Z, C_W, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 4'd7);
			6'd24: r = mk_op(C_X, C_X, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 4'd8);
			6'd25: r = mk_op(C_Z, C_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 4'd8);
			6'd26: r = mk_op(C_Y, C_Z, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd9);
			6'd27: r = mk_op(C_X, C_W, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd9);
			6'd28: r = mk_op(C_X, C_Z, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd10);
			6'd29: r = mk_op(C_Y, C_W, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd10);
			6'd30: r = mk_op(C_Y, C_Z, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd11);
			6'd31: r = mk_op(C_X, C_W, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 4'd11);
			6'd32: r = mk_op(C_X, C_X, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 4'd12);
			6'd33: r = mk_op(C_Y, C_Y, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 4'd12);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/qoa_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qoa_dpath
// Stored quaternion, shared multiplier, accumulator and round/saturate stage.
// ----------------------------------------------------------------------------
module qoa_dpath #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 14
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire qoa_pkg::cmd_t                  cmd,
	output qoa_pkg::sts_t                       sts,
	input  wire logic signed [DATA_WIDTH-1:0]   in_x,
	input  wire logic signed [DATA_WIDTH-1:0]   in_y,
	input  wire logic signed [DATA_WIDTH-1:0]   in_z,
	input  wire logic signed [DATA_WIDTH-1:0]   in_w,
	output logic        [8:0][DATA_WIDTH-1:0]   mat
);

	localparam int PW = 2 * DATA_WIDTH;
	localparam int BW = (2 * FRAC_BITS + 2 > PW) ? 2 * FRAC_BITS + 2 : PW;
	localparam int AW = BW + 4;

	localparam logic signed [AW-1:0] ONE_AC  = AW'(1) << (2 * FRAC_BITS);
	localparam logic signed [AW-1:0] HALF_AC = AW'(1) << (FRAC_BITS - 1);
	localparam logic signed [AW-1:0] DMAX_AC =
		$signed({{(AW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
	localparam logic signed [AW-1:0] DMIN_AC =
		$signed({{(AW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}});
	localparam logic signed [DATA_WIDTH-1:0] W_RESET =
		DATA_WIDTH'(1) << FRAC_BITS;

	logic signed [DATA_WIDTH-1:0] ox_q, oy_q, oz_q, ow_q;
	logic signed [DATA_WIDTH-1:0] gx_q, gy_q, gz_q, gw_q;
	logic signed [DATA_WIDTH-1:0] nx_q, ny_q, nz_q, nw_q;
	logic        [8:0][DATA_WIDTH-1:0] mat_q;

	qoa_pkg::op_t                 op;
	logic signed [DATA_WIDTH-1:0] a_op, b_op, b_orient, b_given;
	logic signed [PW-1:0]         prod_c;

	logic signed [PW-1:0]         prod_s1;
	qoa_pkg::op_t                 op_s1;
	logic                         v_s1;

	logic signed [AW-1:0]         acc_q;
	logic signed [AW-1:0]         sh_c, term_c, base_c, sum_c;
	logic signed [AW-1:0]         fin_s2;
	logic [qoa_pkg::DEST_W-1:0]   dest_s2;
	logic                         v_s2;

	logic signed [AW-1:0]         rnd_c, shr_c;
	logic signed [DATA_WIDTH-1:0] sat_c;
	logic [qoa_pkg::DEST_W-1:0]   mat_idx;

	// stage 1: select operands, multiply
	always_comb begin
		op = qoa_pkg::step_op(cmd.step);
		unique case (op.a_sel)
			qoa_pkg::C_X: a_op = ox_q;
			qoa_pkg::C_Y: a_op = oy_q;
			qoa_pkg::C_Z: a_op = oz_q;
			qoa_pkg::C_W: a_op = ow_q;
			default:      a_op = ow_q;
		endcase
		unique case (op.b_sel)
			qoa_pkg::C_X: begin b_orient = ox_q; b_given = gx_q; end
			qoa_pkg::C_Y: begin b_orient = oy_q; b_given = gy_q; end
			qoa_pkg::C_Z: begin b_orient = oz_q; b_given = gz_q; end
			qoa_pkg::C_W: begin b_orient = ow_q; b_given = gw_q; end
			default:      begin b_orient = ow_q; b_given = gw_q; end
		endcase
		b_op   = op.b_given ? b_given : b_orient;
		prod_c = PW'(a_op) * PW'(b_op);
	end

	// stage 2: scale by one or two, negate via inverted term plus carry in, add to accumulator or start value
	always_comb begin
		sh_c   = op_s1.dbl ? (AW'(prod_s1) <<< 1) : AW'(prod_s1);
		term_c = op_s1.neg ? ~sh_c : sh_c;
		if (op_s1.first) begin
			base_c = op_s1.ones ? ONE_AC : '0;
		end else begin
			base_c = acc_q;
		end
		sum_c = base_c + term_c + AW'(op_s1.neg);
	end

	// stage 3: round half up, saturate
	always_comb begin
		rnd_c = fin_s2 + HALF_AC;
		shr_c = rnd_c >>> FRAC_BITS;
		if (shr_c > DMAX_AC) begin
			sat_c = DMAX_AC[DATA_WIDTH-1:0];
		end else if (shr_c < DMIN_AC) begin
			sat_c = DMIN_AC[DATA_WIDTH-1:0];
		end else begin
			sat_c = shr_c[DATA_WIDTH-1:0];
		end
		mat_idx = dest_s2 - qoa_pkg::DEST_MAT0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ox_q <= '0;
			oy_q <= '0;
			oz_q <= '0;
			ow_q <= W_RESET;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1 && op_s1.last;
			if (cmd.load_orient) begin
				ox_q <= in_x;
				oy_q <= in_y;
				oz_q <= in_z;
				ow_q <= in_w;
			end else if (cmd.commit) begin
				ox_q <= nx_q;
				oy_q <= ny_q;
				oz_q <= nz_q;
				ow_q <= nw_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			gx_q <= in_x;
			gy_q <= in_y;
			gz_q <= in_z;
			gw_q <= in_w;
		end
		if (cmd.issue) begin
			prod_s1 <= prod_c;
			op_s1   <= op;
		end
		if (v_s1) begin
			acc_q <= sum_c;
			if (op_s1.last) begin
				fin_s2  <= sum_c;
				dest_s2 <= op_s1.dest;
			end
		end
		if (v_s2) begin
			if (dest_s2 < qoa_pkg::DEST_MAT0) begin
				case (dest_s2[1:0])
					2'd0:    nx_q <= sat_c;
					2'd1:    ny_q <= sat_c;
					2'd2:    nz_q <= sat_c;
					default: nw_q <= sat_c;
				endcase
			end else begin
				mat_q[mat_idx] <= sat_c;
			end
		end
	end

	assign sts.pipe_busy = v_s1 || v_s2;
	assign mat           = mat_q;

endmodule
`default_nettype wire

@@ design/qoa_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qoa_ctrl
// Sequencer: input/output handshake and the step schedule of the datapath.
// ----------------------------------------------------------------------------
module qoa_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire                 command,
	output logic                out_valid,
	input  wire                 out_stall,
	output qoa_pkg::cmd_t       cmd,
	input  wire qoa_pkg::sts_t  sts
);

	qoa_pkg::state_t             state_q, state_d;
	logic [qoa_pkg::STEP_W-1:0]  step_q, step_d;
	logic                        out_valid_q, present;
	logic                        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qoa_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (present) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d         = state_q;
		step_d          = step_q;
		in_stall        = 1'b1;
		present         = 1'b0;
		accept          = 1'b0;
		cmd             = '0;
		cmd.step        = step_q;
		unique case (state_q)
			qoa_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (command == qoa_pkg::CMD_MUL) begin
						step_d  = qoa_pkg::HAM_FIRST;
						state_d = qoa_pkg::ST_HAM;
					end else begin
						cmd.load_orient = 1'b1;
						step_d          = qoa_pkg::MAT_FIRST;
						state_d         = qoa_pkg::ST_WAIT;
					end
				end
			end
			qoa_pkg::ST_HAM: begin
				cmd.issue = 1'b1;
				step_d    = step_q + 1'b1;
				if (step_q == qoa_pkg::HAM_LAST) begin
					state_d = qoa_pkg::ST_HDRAIN;
				end
			end
			qoa_pkg::ST_HDRAIN: begin
				// new quaternion lands only after the last product drains
				if (!sts.pipe_busy) begin
					cmd.commit = 1'b1;
					state_d    = qoa_pkg::ST_WAIT;
				end
			end
			qoa_pkg::ST_WAIT: begin
				// matrix entries write straight into the output word
				if (!out_valid_q) begin
					state_d = qoa_pkg::ST_MAT;
				end
			end
			qoa_pkg::ST_MAT: begin
				cmd.issue = 1'b1;
				step_d    = step_q + 1'b1;
				if (step_q == qoa_pkg::MAT_LAST) begin
					state_d = qoa_pkg::ST_MDRAIN;
				end
			end
			qoa_pkg::ST_MDRAIN: begin
				if (!sts.pipe_busy) begin
					present = 1'b1;
					state_d = qoa_pkg::ST_IDLE;
				end
			end
			default: state_d = qoa_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input taken while a word is in flight");

	a_issue_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (state_q == qoa_pkg::ST_HAM || state_q == qoa_pkg::ST_MAT))
		else $error("multiplier issued outside a compute phase");

	a_present_empty: assert property (@(posedge clk) disable iff (!arst_n)
		present |-> !sts.pipe_busy)
		else $error("result shown before the pipeline drained");

	a_mat_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == qoa_pkg::ST_MAT || state_q == qoa_pkg::ST_MDRAIN) |-> !out_valid_q)
		else $error("matrix written while the output word is pending");

	a_commit_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $past(state_q == qoa_pkg::ST_HAM, 3) || !sts.pipe_busy)
		else $error("quaternion committed with products in flight");

endmodule
`default_nettype wire

@@ design/quaternion_orientation_accumulator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_orientation_accumulator_top
// Orientation quaternion accumulator with rotation matrix output.
//
// Input channel (in_valid/in_stall): command plus a quaternion in signed
// fixed point. Command 0 loads it; command 1 replaces the stored quaternion
// by stored * given (Hamilton product). Every input word yields one output
// word (out_valid/out_stall): the 3x3 rotation matrix of the stored
// quaternion, column by column, each entry rounded and saturated.
// One shared multiplier does one product per cycle: a load runs the 18
// matrix products and then the pipeline drain, a multiply runs the 16
// quaternion products, drain and commit, then the 18 matrix products.
// A new word is accepted once the previous one is computed, even while its
// result still waits on a stalled receiver; the next matrix phase then
// holds until that result is taken.
// Reset: stored quaternion is the identity rotation (w = 1.0), no output.
// ----------------------------------------------------------------------------
module quaternion_orientation_accumulator_top #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 14
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire                               command,
	input  wire logic signed [DATA_WIDTH-1:0] in_x,
	input  wire logic signed [DATA_WIDTH-1:0] in_y,
	input  wire logic signed [DATA_WIDTH-1:0] in_z,
	input  wire logic signed [DATA_WIDTH-1:0] in_w,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic signed [DATA_WIDTH-1:0]      col0_x,
	output logic signed [DATA_WIDTH-1:0]      col0_y,
	output logic signed [DATA_WIDTH-1:0]      col0_z,
	output logic signed [DATA_WIDTH-1:0]      col1_x,
	output logic signed [DATA_WIDTH-1:0]      col1_y,
	output logic signed [DATA_WIDTH-1:0]      col1_z,
	output logic signed [DATA_WIDTH-1:0]      col2_x,
	output logic signed [DATA_WIDTH-1:0]      col2_y,
	output logic signed [DATA_WIDTH-1:0]      col2_z
);

	qoa_pkg::cmd_t              cmd;
	qoa_pkg::sts_t              sts;
	logic [8:0][DATA_WIDTH-1:0] mat;

	qoa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	qoa_dpath #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.in_x   (in_x),
		.in_y   (in_y),
		.in_z   (in_z),
		.in_w   (in_w),
		.mat    (mat)
	);

	assign col0_x = mat[0];
	assign col0_y = mat[1];
	assign col0_z = mat[2];
	assign col1_x = mat[3];
	assign col1_y = mat[4];
	assign col1_z = mat[5];
	assign col2_x = mat[6];
	assign col2_y = mat[7];
	assign col2_z = mat[8];

endmodule
`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quaternion orientation accumulator. Load and
// multiply words go in through a bursty sender. A local model tracks the
// stored quaternion and predicts each rotation matrix. A monitor compares
// every result, entry by entry, against the oldest prediction while the
// receiver stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module tb;

	localparam int     DW           = 16;
	localparam int     FB           = 14;
	localparam longint HALF_LSB     = longint'(1) << (FB - 1);
	localparam longint UNITY_SQ     = longint'(1) << (2 * FB);
	localparam longint Q_MAX        = (longint'(1) << (DW - 1)) - 1;
	localparam longint Q_MIN        = -(longint'(1) << (DW - 1));
	localparam logic signed [DW-1:0] ONE_Q = 16'sd16384;
	localparam int     RANDOM_WORDS = 750;
	localparam int     TAIL_CYCLES  = 120;
	localparam int     PRINT_CAP    = 100;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
		logic signed [DW-1:0] w;
	} quat_t;

	typedef logic [8:0][DW-1:0] matrix_t;

	typedef struct {
		logic  cmd;
		quat_t q;
		bit    wait_idle;
	} word_t;

	typedef enum logic [1:0] {
		VAL_FULL,
		VAL_UNIT,
		VAL_HALF,
		VAL_EDGE
	} val_style_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_COIN,
		RX_LIGHT,
		RX_LONG
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = qoa_pkg::CMD_LOAD;
	logic signed [DW-1:0] in_x = '0;
	logic signed [DW-1:0] in_y = '0;
	logic signed [DW-1:0] in_z = '0;
	logic signed [DW-1:0] in_w = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DW-1:0] col0_x, col0_y, col0_z;
	logic signed [DW-1:0] col1_x, col1_y, col1_z;
	logic signed [DW-1:0] col2_x, col2_y, col2_z;

	word_t   word_queue[$];
	matrix_t expected_mats[$];
	quat_t   orient;
	int      error_count = 0;
	int      burst_left = 0;
	int      gap_left = 0;
	rx_mode_t rx_mode = RX_FREE;
	int      rx_left = 0;
	int      rx_run = 0;
	logic    rx_level = 1'b0;

	quaternion_orientation_accumulator_top uut (
		.clk, .arst_n,
		.in_valid, .in_stall, .command, .in_x, .in_y, .in_z, .in_w,
		.out_valid, .out_stall,
		.col0_x, .col0_y, .col0_z,
		.col1_x, .col1_y, .col1_z,
		.col2_x, .col2_y, .col2_z
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report(input string msg);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic longint full_prod(input logic signed [DW-1:0] a,
			input logic signed [DW-1:0] b);
		return longint'(a) * longint'(b);
	endfunction

	// round half up once, then clamp to the Q2.14 range
	function automatic logic signed [DW-1:0] round_sat(input longint acc);
		longint r;
		r = (acc + HALF_LSB) >>> FB;
		if (r > Q_MAX)
			r = Q_MAX;
		else if (r < Q_MIN)
			r = Q_MIN;
		return DW'(r);
	endfunction

	// advance the tracked orientation and queue the matrix it yields
	task automatic accept_word(input logic cmd, input quat_t g);
		quat_t   o;
		matrix_t m;
		if (cmd == qoa_pkg::CMD_LOAD) begin
			orient = g;
		end else begin
			o = orient;
			orient.x = round_sat(full_prod(o.w, g.x) + full_prod(o.x, g.w)
				+ full_prod(o.y, g.z) - full_prod(o.z, g.y));
			orient.y = round_sat(full_prod(o.w, g.y) - full_prod(o.x, g.z)
				+ full_prod(o.y, g.w) + full_prod(o.z, g.x));
			orient.z = round_sat(full_prod(o.w, g.z) + full_prod(o.x, g.y)
				- full_prod(o.y, g.x) + full_prod(o.z, g.w));
			orient.w = round_sat(full_prod(o.w, g.w) - full_prod(o.x, g.x)
				- full_prod(o.y, g.y) - full_prod(o.z, g.z));
		end
		o = orient;
		m[0] = round_sat(UNITY_SQ - 2 * full_prod(o.y, o.y) - 2 * full_prod(o.z, o.z));
		m[1] = round_sat(2 * full_prod(o.x, o.y) + 2 * full_prod(o.z, o.w));
		m[2] = round_sat(2 * full_prod(o.x, o.z) - 2 * full_prod(o.y, o.w));
		m[3] = round_sat(2 * full_prod(o.x, o.y) - 2 * full_prod(o.z, o.w));
		m[4] = round_sat(UNITY_SQ - 2 * full_prod(o.x, o.x) - 2 * full_prod(o.z, o.z));
		m[5] = round_sat(2 * full_prod(o.y, o.z) + 2 * full_prod(o.x, o.w));
		m[6] = round_sat(2 * full_prod(o.x, o.z) + 2 * full_prod(o.y, o.w));
		m[7] = round_sat(2 * full_prod(o.y, o.z) - 2 * full_prod(o.x, o.w));
		m[8] = round_sat(UNITY_SQ - 2 * full_prod(o.x, o.x) - 2 * full_prod(o.y, o.y));
		expected_mats.push_back(m);
	endtask

	// sender: bursts of words separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= qoa_pkg::CMD_LOAD;
			in_x <= '0;
			in_y <= '0;
			in_z <= '0;
			in_w <= '0;
			orient.x = '0;
			orient.y = '0;
			orient.z = '0;
			orient.w = ONE_Q;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				accept_word(command, {in_x, in_y, in_z, in_w});
			// hold a stalled word; otherwise pick what goes next
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (word_queue.size() != 0 &&
						!(word_queue[0].wait_idle && expected_mats.size() != 0)) begin
					word_t nxt;
					nxt = word_queue.pop_front();
					command <= nxt.cmd;
					in_x <= nxt.q.x;
					in_y <= nxt.q.y;
					in_z <= nxt.q.z;
					in_w <= nxt.q.w;
					in_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 48);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall behavior switches between modes every so often
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_mode = RX_FREE;
			rx_left = 0;
			rx_run = 0;
			rx_level = 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 300);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_FREE: out_stall <= 1'b0;
				RX_COIN: out_stall <= $urandom_range(0, 1) != 0;
				RX_LIGHT: out_stall <= $urandom_range(0, 7) == 0;
				default: begin
					if (rx_run == 0) begin
						rx_level = ~rx_level;
						rx_run = $urandom_range(1, 64);
					end else begin
						rx_run--;
					end
					out_stall <= rx_level;
				end
			endcase
		end
	end

	// checker: compare each taken matrix against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			matrix_t seen;
			matrix_t want;
			string   axes;
			axes = "xyz";
			seen = {col2_z, col2_y, col2_x, col1_z, col1_y, col1_x, col0_z, col0_y, col0_x};
			if (expected_mats.size() == 0) begin
				report("matrix arrived with no word outstanding");
			end else begin
				want = expected_mats.pop_front();
				for (int k = 0; k < 9; k++)
					if (seen[k] !== want[k])
						report($sformatf("col%0d_%c got %0d want %0d", k / 3, axes[k % 3],
							$signed(seen[k]), $signed(want[k])));
			end
		end
	end

	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic add_word(input logic cmd, input logic signed [DW-1:0] x,
			input logic signed [DW-1:0] y, input logic signed [DW-1:0] z,
			input logic signed [DW-1:0] w, input bit wait_idle);
		word_t wd;
		wd.cmd = cmd;
		wd.q = {x, y, z, w};
		wd.wait_idle = wait_idle;
		word_queue.push_back(wd);
	endtask

	function automatic logic signed [DW-1:0] rand_comp(input val_style_t style);
		case (style)
			VAL_FULL: return DW'($urandom_range(0, 65535));
			VAL_UNIT: return DW'(int'($urandom_range(0, 32768)) - 16384);
			VAL_HALF: return DW'(int'($urandom_range(0, 16384)) - 8192);
			default: begin
				case ($urandom_range(0, 6))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'sd0;
					3: return -16'sd1;
					4: return 16'sd1;
					5: return ONE_Q;
					default: return -ONE_Q;
				endcase
			end
		endcase
	endfunction

	initial begin : stimulus
		int         n;
		int         seg_len;
		val_style_t seg_style;
		val_style_t style;
		logic       cmd;

		// multiply straight out of reset checks the identity start
		add_word(qoa_pkg::CMD_MUL, 16'sd0, 16'sd0, 16'sd0, ONE_Q, 1'b0);
		add_word(qoa_pkg::CMD_MUL, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 1'b0);
		add_word(qoa_pkg::CMD_MUL, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585, 1'b0);
		add_word(qoa_pkg::CMD_MUL, 16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 1'b0);
		// saturating matrix and saturating product
		add_word(qoa_pkg::CMD_LOAD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
		add_word(qoa_pkg::CMD_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
		add_word(qoa_pkg::CMD_LOAD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
		add_word(qoa_pkg::CMD_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
		add_word(qoa_pkg::CMD_MUL, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
		// zero quaternion: no normalization, diagonal stays at one
		add_word(qoa_pkg::CMD_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		add_word(qoa_pkg::CMD_MUL, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
		add_word(qoa_pkg::CMD_LOAD, ONE_Q, 16'sd0, 16'sd0, 16'sd0, 1'b0);
		add_word(qoa_pkg::CMD_LOAD, 16'sd0, -ONE_Q, 16'sd0, 16'sd0, 1'b0);
		add_word(qoa_pkg::CMD_LOAD, 16'sd0, 16'sd0, ONE_Q, 16'sd0, 1'b0);
		add_word(qoa_pkg::CMD_LOAD, 16'sd0, 16'sd0, 16'sd0, -ONE_Q, 1'b0);
		add_word(qoa_pkg::CMD_MUL, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 1'b0);
		// tiny values exercise the rounding point
		add_word(qoa_pkg::CMD_LOAD, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0);
		add_word(qoa_pkg::CMD_MUL, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b0);
		add_word(qoa_pkg::CMD_LOAD, 16'sh7fff, 16'sh8000, 16'sd0, ONE_Q, 1'b0);
		add_word(qoa_pkg::CMD_MUL, 16'sh8000, 16'sd0, 16'sh7fff, -ONE_Q, 1'b0);
		add_word(qoa_pkg::CMD_LOAD, 16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192,
			1'b0);
		add_word(qoa_pkg::CMD_MUL, -16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192,
			1'b0);

		// random: a load followed by a chain of multiplies, with some noise
		n = 0;
		while (n < RANDOM_WORDS) begin
			case ($urandom_range(0, 9))
				6, 7: seg_style = VAL_HALF;
				8: seg_style = VAL_FULL;
				9: seg_style = VAL_EDGE;
				default: seg_style = VAL_UNIT;
			endcase
			seg_len = $urandom_range(1, 12);
			for (int j = 0; j < seg_len; j++) begin
				cmd = (j == 0) ? qoa_pkg::CMD_LOAD : qoa_pkg::CMD_MUL;
				if ($urandom_range(0, 9) == 0)
					cmd = ($urandom_range(0, 1) == 0) ? qoa_pkg::CMD_LOAD : qoa_pkg::CMD_MUL;
				style = seg_style;
				if ($urandom_range(0, 6) == 0)
					style = val_style_t'($urandom_range(0, 3));
				add_word(cmd, rand_comp(style), rand_comp(style), rand_comp(style),
					rand_comp(style), (n % 97) == 0);
				n++;
			end
		end

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		while (word_queue.size() != 0 || in_valid || expected_mats.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
